// ===== design/crps_pkg.sv =====
// ----------------------------------------------------------------------------
// crps_pkg
// Shared constants and types for the Catmull-Rom path sampler.
// ----------------------------------------------------------------------------
package crps_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W      = ($clog2(MAX_POINTS + 1) > 7) ? $clog2(MAX_POINTS + 1) : 7;
   localparam int COORD_W    = 32;
   localparam int POINT_W    = 3 * COORD_W;
   localparam int PARAM_W    = 17;
   localparam int U_W        = 17;
   localparam int VAL_W      = 40;
   localparam int PROD_W     = VAL_W + U_W + 1;
   localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(65536);

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   typedef logic signed [VAL_W-1:0]   val_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [U_W-1:0]            u_type;

endpackage

// ===== design/crps_ram.sv =====
// ----------------------------------------------------------------------------
// crps_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/catmull_rom_path_sampler_top.sv =====
// ----------------------------------------------------------------------------
// catmull_rom_path_sampler_top
// Uniform Catmull-Rom position and tangent sampling over a stored point table.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while rsp_tready does not stall the output.
// A sample beat passes eight register stages to its result beat; the Horner
// chain's multiplies sit in the product stages; four table read ports (one RAM copy per neighbor).
// Load beats write the table in the accept cycle and produce no result.
// Reset clears point_count and pipeline valids; the table is not cleared.
module catmull_rom_path_sampler_top
   import crps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data,    // point_count
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [119:0] req_tdata,      // point_index, point_x, point_y, point_z, path_param
   input  logic         req_tuser,      // mode
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,      // pos_x, pos_y, pos_z, tan_x, tan_y, tan_z
   output logic         rsp_tuser       // ok
);

   localparam int NS = 8;

   logic [6:0] count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // ---------------- handshake chain ----------------
   logic [NS:1] v_ff, v_in, en;
   always_comb begin
      en[NS] = !v_ff[NS] || rsp_tready;
      for (int k = NS - 1; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_tready = en[1];
   logic acc, acc_sample, acc_load;
   assign acc        = req_tvalid && req_tready;
   assign acc_sample = acc && (req_tuser == MODE_SAMPLE);
   assign acc_load   = acc && (req_tuser == MODE_LOAD);

   always_comb begin
      v_in[1] = en[1] ? acc_sample : v_ff[1];
      for (int k = 2; k <= NS; k++) begin
         v_in[k] = en[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // ---------------- stage 0: index and local parameter ----------------
   logic [5:0]          slot;
   logic [POINT_W-1:0]  wr_point;
   logic [PARAM_W-1:0]  t_raw, t_c;
   logic [CNT_W-1:0]    n, seg, cap, i_s, i0, i2;
   logic [CNT_W:0]      i3w;
   logic [CNT_W-1:0]    i3;
   logic [PARAM_W+CNT_W-1:0] scaled, base;
   logic [CNT_W:0]      i_raw;
   logic                few;
   u_type               u0;

   assign slot     = req_tdata[5:0];
   assign wr_point = req_tdata[101:6];
   assign t_raw    = req_tdata[118:102];

   always_comb begin
      t_c    = (t_raw > PARAM_ONE) ? PARAM_ONE : t_raw;
      n      = (CNT_W'(count_ff) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
                                                        : CNT_W'(count_ff);
      few    = n < CNT_W'(2);
      seg    = n - CNT_W'(1);
      cap    = n - CNT_W'(2);
      scaled = (PARAM_W+CNT_W)'(t_c) * (PARAM_W+CNT_W)'(seg);
      i_raw  = (CNT_W+1)'(scaled >> 16);
      i_s    = (i_raw > {1'b0, cap}) ? cap : i_raw[CNT_W-1:0];
      base   = (PARAM_W+CNT_W)'(i_s) << 16;
      u0     = U_W'(scaled - base);
      i0     = (i_s == '0) ? '0 : i_s - CNT_W'(1);
      i2     = i_s + CNT_W'(1);
      i3w    = {1'b0, i_s} + (CNT_W+1)'(2);
      i3     = (i3w > {1'b0, seg}) ? seg : i3w[CNT_W-1:0];
   end

   logic [IDX_W-1:0] rd_addr [4];
   assign rd_addr[0] = i0[IDX_W-1:0];
   assign rd_addr[1] = i_s[IDX_W-1:0];
   assign rd_addr[2] = i2[IDX_W-1:0];
   assign rd_addr[3] = i3[IDX_W-1:0];

   logic wr_ok;
   assign wr_ok = acc_load && ({1'b0, slot} < 7'(MAX_POINTS));

   logic [POINT_W-1:0] rd_data [4];
   for (genvar g = 0; g < 4; g++) begin : g_tbl
      crps_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_tbl (
         .clock   (clock),
         .wr_en   (wr_ok),
         .wr_addr (slot[IDX_W-1:0]),
         .wr_data (wr_point),
         .rd_en   (en[1]),
         .rd_addr (rd_addr[g]),
         .rd_data (rd_data[g])
      );
   end

   u_type u1_ff;
   logic  ok1_ff;
   always_ff @(posedge clock) begin
      if (en[1]) begin
         u1_ff  <= u0;
         ok1_ff <= !few;
      end
   end

   // ---------------- stage 1: basis coefficients ----------------
   val_type a_c [3], b_c [3], c_c [3], d_c [3], e_c [3];
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         val_type p0, p1, p2, p3;
         p0 = VAL_W'(coord_type'(rd_data[0][j*COORD_W +: COORD_W]));
         p1 = VAL_W'(coord_type'(rd_data[1][j*COORD_W +: COORD_W]));
         p2 = VAL_W'(coord_type'(rd_data[2][j*COORD_W +: COORD_W]));
         p3 = VAL_W'(coord_type'(rd_data[3][j*COORD_W +: COORD_W]));
         a_c[j] = p1 <<< 1;
         b_c[j] = p2 - p0;
         c_c[j] = (p0 <<< 1) - 5 * p1 + (p2 <<< 2) - p3;
         d_c[j] = 3 * (p1 - p2) + p3 - p0;
         e_c[j] = 3 * d_c[j];
      end
   end

   val_type a2_ff [3], b2_ff [3], c2_ff [3], d2_ff [3], e2_ff [3];
   u_type   u2_ff;
   logic    ok2_ff;
   always_ff @(posedge clock) begin
      if (en[2]) begin
         a2_ff  <= a_c;
         b2_ff  <= b_c;
         c2_ff  <= c_c;
         d2_ff  <= d_c;
         e2_ff  <= e_c;
         u2_ff  <= u1_ff;
         ok2_ff <= ok1_ff;
      end
   end

   function automatic prod_type mul_u(val_type v, u_type u);
      return PROD_W'(v) * PROD_W'(signed'({1'b0, u}));
   endfunction

   function automatic val_type rnd16(prod_type p);
      prod_type s;
      s = (p + PROD_W'(32768)) >>> 16;
      return s[VAL_W-1:0];
   endfunction

   function automatic coord_type half_sat(val_type v);
      val_type h;
      h = (v + VAL_W'(1)) >>> 1;
      if (h > VAL_W'(32'sh7FFFFFFF)) begin
         return 32'sh7FFFFFFF;
      end else if (h < -VAL_W'(64'sh80000000)) begin
         return 32'sh80000000;
      end
      return h[COORD_W-1:0];
   endfunction

   // ---------------- stage 2: first products ----------------
   val_type  a3_ff [3], b3_ff [3], c3_ff [3];
   prod_type m3_ff [3], n3_ff [3];
   u_type    u3_ff;
   logic     ok3_ff;
   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int j = 0; j < 3; j++) begin
            m3_ff[j] <= mul_u(d2_ff[j], u2_ff);
            n3_ff[j] <= mul_u(e2_ff[j], u2_ff);
         end
         a3_ff  <= a2_ff;
         b3_ff  <= b2_ff;
         c3_ff  <= c2_ff;
         u3_ff  <= u2_ff;
         ok3_ff <= ok2_ff;
      end
   end

   // ---------------- stage 3: round and add c ----------------
   val_type a4_ff [3], b4_ff [3], v4_ff [3], w4_ff [3];
   u_type   u4_ff;
   logic    ok4_ff;
   always_ff @(posedge clock) begin
      if (en[4]) begin
         for (int j = 0; j < 3; j++) begin
            v4_ff[j] <= rnd16(m3_ff[j]) + c3_ff[j];
            w4_ff[j] <= rnd16(n3_ff[j]) + (c3_ff[j] <<< 1);
         end
         a4_ff  <= a3_ff;
         b4_ff  <= b3_ff;
         u4_ff  <= u3_ff;
         ok4_ff <= ok3_ff;
      end
   end

   // ---------------- stage 4: second products ----------------
   val_type  a5_ff [3], b5_ff [3];
   prod_type pv5_ff [3], pw5_ff [3];
   u_type    u5_ff;
   logic     ok5_ff;
   always_ff @(posedge clock) begin
      if (en[5]) begin
         for (int j = 0; j < 3; j++) begin
            pv5_ff[j] <= mul_u(v4_ff[j], u4_ff);
            pw5_ff[j] <= mul_u(w4_ff[j], u4_ff);
         end
         a5_ff  <= a4_ff;
         b5_ff  <= b4_ff;
         u5_ff  <= u4_ff;
         ok5_ff <= ok4_ff;
      end
   end

   // ---------------- stage 5: add b, finish tangent ----------------
   val_type   a6_ff [3], v6_ff [3];
   coord_type t6_ff [3];
   u_type     u6_ff;
   logic      ok6_ff;
   always_ff @(posedge clock) begin
      if (en[6]) begin
         for (int j = 0; j < 3; j++) begin
            v6_ff[j] <= rnd16(pv5_ff[j]) + b5_ff[j];
            t6_ff[j] <= half_sat(rnd16(pw5_ff[j]) + b5_ff[j]);
         end
         a6_ff  <= a5_ff;
         u6_ff  <= u5_ff;
         ok6_ff <= ok5_ff;
      end
   end

   // ---------------- stage 6: last product ----------------
   val_type   a7_ff [3];
   prod_type  pv7_ff [3];
   coord_type t7_ff [3];
   logic      ok7_ff;
   always_ff @(posedge clock) begin
      if (en[7]) begin
         for (int j = 0; j < 3; j++) begin
            pv7_ff[j] <= mul_u(v6_ff[j], u6_ff);
         end
         a7_ff  <= a6_ff;
         t7_ff  <= t6_ff;
         ok7_ff <= ok6_ff;
      end
   end

   // ---------------- stage 7: position, zero tangent, output ----------------
   coord_type pos_in [3], tan_in [3];
   logic      tan_zero;
   always_comb begin
      tan_zero = (t7_ff[0] == '0) && (t7_ff[1] == '0) && (t7_ff[2] == '0);
      for (int j = 0; j < 3; j++) begin
         pos_in[j] = ok7_ff ? half_sat(rnd16(pv7_ff[j]) + a7_ff[j]) : '0;
         tan_in[j] = ok7_ff ? t7_ff[j] : '0;
      end
      if (ok7_ff && tan_zero) begin
         tan_in[2] = 32'shFFFF0000;
      end
   end

   coord_type pos_ff [3], tan_ff [3];
   logic      ok_ff;
   always_ff @(posedge clock) begin
      if (en[8]) begin
         pos_ff <= pos_in;
         tan_ff <= tan_in;
         ok_ff  <= ok7_ff;
      end
   end

   assign rsp_tvalid = v_ff[NS];
   assign rsp_tuser  = ok_ff;
   assign rsp_tdata  = {tan_ff[2], tan_ff[1], tan_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};

endmodule
